// File: hdl/fte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fte_pkg;

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_RESERVE = 2'd2,
        OP_FLUSH   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_FAT_TYPE      = 2'd0,
        REG_CLUSTER_COUNT = 2'd1,
        REG_BLOCK_LOG2    = 2'd2,
        REG_NONE          = 2'd3
    } cfg_reg_t;

    localparam logic [1:0]  FAT12    = 2'd0;
    localparam logic [1:0]  FAT16    = 2'd1;
    localparam logic [27:0] MASK12   = 28'hFFF;
    localparam logic [27:0] MASK16   = 28'hFFFF;
    localparam logic [27:0] MASK28   = 28'hFFFFFFF;
    localparam logic [27:0] END_MARK = 28'hFFFFFFF;
    localparam logic [31:0] DIRTY_LOW_INIT = 32'hFFFFFFFF;
    localparam logic [27:0] FIRST_SCAN = 28'd2;

endpackage
`default_nettype wire

// File: hdl/fte_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module fte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: hdl/fat_table_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// File allocation table engine (FAT12 / FAT16 / FAT32) over a byte store.
// Command channel: an item is taken when start is high and busy is low;
// operation selects read entry, write entry, reserve clusters or flush.
// Result: one item per command, on the result ports for one cycle while
// done is high. Ports an operation does not use read zero.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready
// is always high, writes land at once.
// Access: the byte store is one RAM with a registered read port, and
// every entry access goes through it one byte at a time, over B = 2 bytes
// (FAT12/16) or 4 bytes (FAT32). A write reads the entry's bytes first and
// then stores them back. Reserve walks clusters upward from 2, linking each
// free cluster from the tail (once there is one) and marking it as the end.
// Reset: the store is swept to zero, one byte a cycle, and busy stays
// high meanwhile. Results cannot be stalled by the receiver.
module fat_table_engine_core #(
    parameter int TABLE_BYTES = 65536
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  operation,
    input  wire logic [27:0] cluster,
    input  wire logic [27:0] next_value,
    input  wire logic [15:0] alloc_count,
    output logic             done,
    output logic [27:0]      entry_value,
    output logic             is_end,
    output logic [27:0]      first_cluster,
    output logic             range_valid,
    output logic [30:0]      range_low,
    output logic [30:0]      range_high,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [27:0] cfg_data
);
    import fte_pkg::*;

    localparam int AW = $clog2(TABLE_BYTES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LD_OFF, S_LD_ADDR, S_LD_DATA, S_AFTER_LD,
        S_ST, S_AFTER_ST, S_RSV_CHK, S_FLUSH
    } state_t;

    typedef enum logic [2:0] {
        STEP_READ, STEP_WRITE, STEP_SCAN, STEP_LINK, STEP_MARK
    } step_t;

    state_t        state_reg, state_next;
    step_t         step_reg;
    logic [1:0]    fat_type_reg;
    logic [27:0]   cluster_count_reg;
    logic [3:0]    block_log2_reg;
    logic [31:0]   dirty_low_reg, dirty_high_reg;
    logic [AW-1:0] clr_reg;
    logic [27:0]   ent_reg, val_reg, cur_reg, tail_reg, first_reg;
    logic [30:0]   off_reg;
    logic [1:0]    idx_reg;
    logic [7:0]    byte_reg [4];
    logic          rd_ok_reg;
    logic [15:0]   cnt_reg;
    logic          done_reg, is_end_reg, range_valid_reg;
    logic [27:0]   entry_value_reg, first_cluster_reg;
    logic [30:0]   range_low_reg, range_high_reg;

    logic          is12, is16;
    logic [27:0]   mask_c, ent_val_c;
    logic [1:0]    last_idx;
    logic [30:0]   off_c;
    logic          fits_c, in_range;
    logic [31:0]   baddr;
    logic [7:0]    wb [4];
    logic [7:0]    rd_data, wr_data;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   lo_b, hi_b, bs_mask, flush_lo, flush_hi;
    logic          dirty_any;

    assign is12     = (fat_type_reg == FAT12);
    assign is16     = (fat_type_reg == FAT16);
    assign mask_c   = is12 ? MASK12 : (is16 ? MASK16 : MASK28);
    assign last_idx = (is12 || is16) ? 2'd1 : 2'd3;

    always_comb
    begin
        if (is12)
        begin
            off_c = 31'(ent_reg) + 31'(ent_reg[27:1]);
        end
        else if (is16)
        begin
            off_c = {2'b0, ent_reg, 1'b0};
        end
        else
        begin
            off_c = {1'b0, ent_reg, 2'b0};
        end
    end

    assign fits_c   = (({1'b0, off_c} + {30'b0, last_idx}) < 32'(TABLE_BYTES));
    assign baddr    = {1'b0, off_reg} + {30'b0, idx_reg};
    assign in_range = (baddr < 32'(TABLE_BYTES));

    always_comb
    begin
        if (is12)
        begin
            if (ent_reg[0])
            begin
                ent_val_c = {16'b0, byte_reg[1], byte_reg[0][7:4]};
            end
            else
            begin
                ent_val_c = {16'b0, byte_reg[1][3:0], byte_reg[0]};
            end
        end
        else if (is16)
        begin
            ent_val_c = {12'b0, byte_reg[1], byte_reg[0]};
        end
        else
        begin
            ent_val_c = {byte_reg[3][3:0], byte_reg[2], byte_reg[1], byte_reg[0]};
        end
    end

    always_comb
    begin
        wb[0] = val_reg[7:0];
        wb[1] = val_reg[15:8];
        wb[2] = val_reg[23:16];
        wb[3] = {byte_reg[3][7:4], val_reg[27:24]};
        if (is12)
        begin
            if (ent_reg[0])
            begin
                wb[0] = {val_reg[3:0], byte_reg[0][3:0]};
                wb[1] = val_reg[11:4];
            end
            else
            begin
                wb[1] = {byte_reg[1][7:4], val_reg[11:8]};
            end
        end
    end

    assign ram_we    = (state_reg == S_CLEAR) || ((state_reg == S_ST) && in_range);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_reg : baddr[AW-1:0];
    assign wr_data   = (state_reg == S_CLEAR) ? 8'd0 : wb[idx_reg];

    fte_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_data),
        .raddr (baddr[AW-1:0]),
        .rdata (rd_data)
    );

    always_comb
    begin
        if (is12)
        begin
            lo_b = 32'(dirty_low_reg[27:0]) + 32'(dirty_low_reg[27:1]);
            hi_b = 32'(dirty_high_reg[27:0]) + 32'(dirty_high_reg[27:1]);
        end
        else if (is16)
        begin
            lo_b = {3'b0, dirty_low_reg[27:0], 1'b0};
            hi_b = {3'b0, dirty_high_reg[27:0], 1'b0};
        end
        else
        begin
            lo_b = {2'b0, dirty_low_reg[27:0], 2'b0};
            hi_b = {2'b0, dirty_high_reg[27:0], 2'b0};
        end
    end

    assign bs_mask   = (32'd1 << block_log2_reg) - 32'd1;
    assign flush_lo  = lo_b & ~bs_mask;
    assign flush_hi  = (hi_b + bs_mask) & ~bs_mask;
    assign dirty_any = (dirty_low_reg <= dirty_high_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == AW'(TABLE_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (op_t'(operation))
                        OP_READ:    state_next = S_LD_OFF;
                        OP_WRITE:   state_next = S_LD_OFF;
                        OP_RESERVE: state_next = S_RSV_CHK;
                        OP_FLUSH:   state_next = S_FLUSH;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_LD_OFF:
            begin
                state_next = (step_reg == STEP_SCAN && !fits_c) ? S_IDLE : S_LD_ADDR;
            end
            S_LD_ADDR:
            begin
                state_next = S_LD_DATA;
            end
            S_LD_DATA:
            begin
                state_next = (idx_reg == last_idx) ? S_AFTER_LD : S_LD_ADDR;
            end
            S_AFTER_LD:
            begin
                case (step_reg)
                    STEP_READ: state_next = S_IDLE;
                    STEP_SCAN: state_next = (ent_val_c == 28'd0) ? S_LD_OFF : S_RSV_CHK;
                    default:   state_next = S_ST;
                endcase
            end
            S_ST:
            begin
                if (idx_reg == last_idx)
                begin
                    state_next = S_AFTER_ST;
                end
            end
            S_AFTER_ST:
            begin
                case (step_reg)
                    STEP_LINK: state_next = S_LD_OFF;
                    STEP_MARK: state_next = S_RSV_CHK;
                    default:   state_next = S_IDLE;
                endcase
            end
            S_RSV_CHK:
            begin
                if (cnt_reg == 16'd0 || cur_reg >= cluster_count_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_LD_OFF;
                end
            end
            S_FLUSH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            step_reg          <= STEP_READ;
            fat_type_reg      <= FAT16;
            cluster_count_reg <= 28'd0;
            block_log2_reg    <= 4'd9;
            dirty_low_reg     <= DIRTY_LOW_INIT;
            dirty_high_reg    <= 32'd0;
            clr_reg           <= '0;
            ent_reg           <= 28'd0;
            val_reg           <= 28'd0;
            cur_reg           <= 28'd0;
            tail_reg          <= 28'd0;
            first_reg         <= 28'd0;
            off_reg           <= 31'd0;
            idx_reg           <= 2'd0;
            for (int i = 0; i < 4; i++)
            begin
                byte_reg[i] <= 8'd0;
            end
            rd_ok_reg         <= 1'b0;
            cnt_reg           <= 16'd0;
            done_reg          <= 1'b0;
            is_end_reg        <= 1'b0;
            range_valid_reg   <= 1'b0;
            entry_value_reg   <= 28'd0;
            first_cluster_reg <= 28'd0;
            range_low_reg     <= 31'd0;
            range_high_reg    <= 31'd0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;

            if (cfg_valid)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_FAT_TYPE:      fat_type_reg      <= cfg_data[1:0];
                    REG_CLUSTER_COUNT: cluster_count_reg <= cfg_data;
                    REG_BLOCK_LOG2:    block_log2_reg    <= cfg_data[3:0];
                    default:           ;
                endcase
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        entry_value_reg   <= 28'd0;
                        is_end_reg        <= 1'b0;
                        first_cluster_reg <= 28'd0;
                        range_valid_reg   <= 1'b0;
                        range_low_reg     <= 31'd0;
                        range_high_reg    <= 31'd0;
                        ent_reg           <= cluster;
                        val_reg           <= next_value & mask_c;
                        first_reg         <= cluster;
                        tail_reg          <= cluster;
                        cur_reg           <= FIRST_SCAN;
                        cnt_reg           <= alloc_count;
                        step_reg          <= (op_t'(operation) == OP_WRITE) ? STEP_WRITE
                                                                            : STEP_READ;
                    end
                end
                S_LD_OFF:
                begin
                    off_reg <= off_c;
                    idx_reg <= 2'd0;
                    if (step_reg == STEP_SCAN && !fits_c)
                    begin
                        first_cluster_reg <= first_reg;
                        done_reg          <= 1'b1;
                    end
                    if (step_reg == STEP_WRITE || step_reg == STEP_LINK
                        || step_reg == STEP_MARK)
                    begin
                        if ({4'b0, ent_reg} < dirty_low_reg)
                        begin
                            dirty_low_reg <= {4'b0, ent_reg};
                        end
                        if ({4'b0, ent_reg} > dirty_high_reg)
                        begin
                            dirty_high_reg <= {4'b0, ent_reg};
                        end
                    end
                end
                S_LD_ADDR:
                begin
                    rd_ok_reg <= in_range;
                end
                S_LD_DATA:
                begin
                    byte_reg[idx_reg] <= rd_ok_reg ? rd_data : 8'd0;
                    idx_reg           <= idx_reg + 2'd1;
                end
                S_AFTER_LD:
                begin
                    idx_reg <= 2'd0;
                    case (step_reg)
                        STEP_READ:
                        begin
                            entry_value_reg <= ent_val_c;
                            is_end_reg      <= (ent_val_c == mask_c);
                            done_reg        <= 1'b1;
                        end
                        STEP_SCAN:
                        begin
                            if (ent_val_c == 28'd0)
                            begin
                                if (tail_reg != 28'd0)
                                begin
                                    ent_reg  <= tail_reg;
                                    val_reg  <= cur_reg & mask_c;
                                    step_reg <= STEP_LINK;
                                end
                                else
                                begin
                                    ent_reg  <= cur_reg;
                                    val_reg  <= END_MARK & mask_c;
                                    step_reg <= STEP_MARK;
                                end
                            end
                            else
                            begin
                                cur_reg <= cur_reg + 28'd1;
                            end
                        end
                        default: ;
                    endcase
                end
                S_ST:
                begin
                    idx_reg <= idx_reg + 2'd1;
                end
                S_AFTER_ST:
                begin
                    case (step_reg)
                        STEP_LINK:
                        begin
                            ent_reg  <= cur_reg;
                            val_reg  <= END_MARK & mask_c;
                            step_reg <= STEP_MARK;
                        end
                        STEP_MARK:
                        begin
                            if (first_reg == 28'd0)
                            begin
                                first_reg <= cur_reg;
                            end
                            tail_reg <= cur_reg;
                            cnt_reg  <= cnt_reg - 16'd1;
                            cur_reg  <= cur_reg + 28'd1;
                        end
                        default:
                        begin
                            done_reg <= 1'b1;
                        end
                    endcase
                end
                S_RSV_CHK:
                begin
                    if (cnt_reg == 16'd0 || cur_reg >= cluster_count_reg)
                    begin
                        first_cluster_reg <= first_reg;
                        done_reg          <= 1'b1;
                    end
                    else
                    begin
                        ent_reg  <= cur_reg;
                        step_reg <= STEP_SCAN;
                    end
                end
                S_FLUSH:
                begin
                    if (dirty_any)
                    begin
                        range_valid_reg <= 1'b1;
                        range_low_reg   <= flush_lo[30:0];
                        range_high_reg  <= flush_hi[30:0];
                    end
                    dirty_low_reg  <= DIRTY_LOW_INIT;
                    dirty_high_reg <= 32'd0;
                    done_reg       <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign cfg_ready     = 1'b1;
    assign done          = done_reg;
    assign entry_value   = entry_value_reg;
    assign is_end        = is_end_reg;
    assign first_cluster = first_cluster_reg;
    assign range_valid   = range_valid_reg;
    assign range_low     = range_low_reg;
    assign range_high    = range_high_reg;
endmodule
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import fte_pkg::*;

    localparam int STORE_BYTES = 65536;
    localparam int IDLE_LIMIT = 400000;

    typedef struct packed {
        logic [27:0] entry_value;
        logic        is_end;
        logic [27:0] first_cluster;
        logic        range_valid;
        logic [30:0] range_low;
        logic [30:0] range_high;
    } fat_result_t;

    typedef struct {
        logic        is_cfg;
        cfg_reg_t    reg_idx;
        logic [27:0] reg_val;
        op_t         op;
        logic [27:0] cl;
        logic [27:0] nv;
        logic [15:0] cnt;
        logic        typed;
        fat_result_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  operation;
    logic [27:0] cluster;
    logic [27:0] next_value;
    logic [15:0] alloc_count;
    logic        done;
    logic [27:0] entry_value;
    logic        is_end;
    logic [27:0] first_cluster;
    logic        range_valid;
    logic [30:0] range_low;
    logic [30:0] range_high;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [27:0] cfg_data;

    fat_table_engine_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .cluster(cluster), .next_value(next_value),
        .alloc_count(alloc_count), .done(done), .entry_value(entry_value),
        .is_end(is_end), .first_cluster(first_cluster), .range_valid(range_valid),
        .range_low(range_low), .range_high(range_high), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    logic [7:0]  fat_store [STORE_BYTES];
    logic [31:0] dirty_lo;
    logic [31:0] dirty_hi;
    logic [1:0]  fat_fmt;
    logic [27:0] clus_limit;
    logic [3:0]  blk_log2;

    fat_result_t pending_results[$];
    int errors = 0;
    int idle_cycles = 0;
    int gap_pct;
    stim_row_t rows[$];

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [7:0] store_rd(longint unsigned a);
        return (a < STORE_BYTES) ? fat_store[a] : 8'h00;
    endfunction

    function automatic void store_wr(longint unsigned a, logic [7:0] v);
        if (a < STORE_BYTES)
            fat_store[a] = v;
    endfunction

    function automatic logic [27:0] fmt_mask();
        if (fat_fmt == FAT12) return MASK12;
        if (fat_fmt == FAT16) return MASK16;
        return MASK28;
    endfunction

    function automatic longint unsigned entry_addr(logic [27:0] n);
        if (fat_fmt == FAT12) return longint'(n) + longint'(n >> 1);
        if (fat_fmt == FAT16) return longint'(n) * 2;
        return longint'(n) * 4;
    endfunction

    function automatic logic [27:0] fat_entry(logic [27:0] n);
        longint unsigned o;
        logic [31:0] v;
        o = entry_addr(n);
        if (fat_fmt == FAT12)
        begin
            if (n[0])
                v = (32'(store_rd(o)) >> 4) | (32'(store_rd(o + 1)) << 4);
            else
                v = (32'(store_rd(o + 1)) << 8) | 32'(store_rd(o));
            return v[27:0] & MASK12;
        end
        if (fat_fmt == FAT16)
            return {12'd0, store_rd(o + 1), store_rd(o)};
        v = {store_rd(o + 3), store_rd(o + 2), store_rd(o + 1), store_rd(o)};
        return v[27:0];
    endfunction

    function automatic void fat_set(logic [27:0] n, logic [27:0] v);
        longint unsigned o;
        o = entry_addr(n);
        if (32'(n) < dirty_lo) dirty_lo = 32'(n);
        if (32'(n) > dirty_hi) dirty_hi = 32'(n);
        if (fat_fmt == FAT12)
        begin
            if (n[0])
            begin
                store_wr(o, (store_rd(o) & 8'h0F) | {v[3:0], 4'h0});
                store_wr(o + 1, v[11:4]);
            end
            else
            begin
                store_wr(o, v[7:0]);
                store_wr(o + 1, (store_rd(o + 1) & 8'hF0) | {4'h0, v[11:8]});
            end
        end
        else if (fat_fmt == FAT16)
        begin
            store_wr(o, v[7:0]);
            store_wr(o + 1, v[15:8]);
        end
        else
        begin
            store_wr(o, v[7:0]);
            store_wr(o + 1, v[15:8]);
            store_wr(o + 2, v[23:16]);
            store_wr(o + 3, (store_rd(o + 3) & 8'hF0) | {4'h0, v[27:24]});
        end
    endfunction

    function automatic longint unsigned byte_of_cluster(logic [31:0] n);
        if (fat_fmt == FAT12) return (longint'(n) * 3) / 2;
        if (fat_fmt == FAT16) return longint'(n) * 2;
        return longint'(n) * 4;
    endfunction

    function automatic fat_result_t fat_predict(op_t op, logic [27:0] cl, logic [27:0] nv,
                                                logic [15:0] cnt);
        fat_result_t r;
        logic [27:0] first;
        logic [27:0] tail;
        logic [27:0] cur;
        logic [27:0] v;
        longint unsigned bs;
        longint unsigned lo;
        longint unsigned hi;
        r = '0;
        case (op)
            OP_READ:
            begin
                v = fat_entry(cl);
                r.entry_value = v;
                r.is_end = (v == fmt_mask());
            end
            OP_WRITE: fat_set(cl, nv & fmt_mask());
            OP_RESERVE:
            begin
                first = cl;
                tail = cl;
                cur = FIRST_SCAN;
                while (cnt != 0 && cur < clus_limit
                       && entry_addr(cur) + ((fat_fmt <= FAT16) ? 1 : 3) < STORE_BYTES)
                begin
                    if (fat_entry(cur) == 0)
                    begin
                        if (tail != 0) fat_set(tail, cur & fmt_mask());
                        fat_set(cur, END_MARK & fmt_mask());
                        if (first == 0) first = cur;
                        tail = cur;
                        cnt--;
                    end
                    cur++;
                end
                r.first_cluster = first;
            end
            default:
            begin
                if (dirty_lo <= dirty_hi)
                begin
                    bs = 64'd1 << blk_log2;
                    lo = byte_of_cluster(dirty_lo) & ~(bs - 1);
                    hi = (byte_of_cluster(dirty_hi) + bs - 1) & ~(bs - 1);
                    r.range_valid = 1'b1;
                    r.range_low = lo[30:0];
                    r.range_high = hi[30:0];
                end
                dirty_lo = DIRTY_LOW_INIT;
                dirty_hi = 32'd0;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        fat_result_t got;
        fat_result_t exp_r;
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
        if (done)
        begin
            got = '{entry_value, is_end, first_cluster, range_valid, range_low, range_high};
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp ev=%h end=%b fc=%h rv=%b lo=%h hi=%h, got ev=%h end=%b fc=%h rv=%b lo=%h hi=%h",
                                 exp_r.entry_value, exp_r.is_end, exp_r.first_cluster,
                                 exp_r.range_valid, exp_r.range_low, exp_r.range_high,
                                 got.entry_value, got.is_end, got.first_cluster,
                                 got.range_valid, got.range_low, got.range_high);
                end
            end
        end
    end

    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [27:0] val);
        start <= 1'b0;
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FAT_TYPE: fat_fmt = val[1:0];
            REG_CLUSTER_COUNT: clus_limit = val;
            REG_BLOCK_LOG2: blk_log2 = val[3:0];
            default: ;
        endcase
    endtask

    task automatic send_item(op_t op, logic [27:0] cl, logic [27:0] nv, logic [15:0] cnt,
                             logic typed, fat_result_t want);
        fat_result_t r;
        if ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        operation <= op;
        cluster <= cl;
        next_value <= nv;
        alloc_count <= cnt;
        do @(posedge clk); while (busy);
        r = fat_predict(op, cl, nv, cnt);
        pending_results.push_back(typed ? want : r);
    endtask

    function automatic stim_row_t cfg_row(cfg_reg_t idx, logic [27:0] val);
        stim_row_t s;
        s.is_cfg = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        s.op = OP_READ;
        s.cl = 28'd0;
        s.nv = 28'd0;
        s.cnt = 16'd0;
        s.typed = 1'b0;
        s.want = '0;
        return s;
    endfunction

    function automatic stim_row_t cmd_row(op_t op, logic [27:0] cl, logic [27:0] nv,
                                          logic [15:0] cnt, logic typed,
                                          logic [27:0] ev, logic ie, logic [27:0] fc);
        stim_row_t s;
        s.is_cfg = 1'b0;
        s.reg_idx = REG_FAT_TYPE;
        s.reg_val = 28'd0;
        s.op = op;
        s.cl = cl;
        s.nv = nv;
        s.cnt = cnt;
        s.typed = typed;
        s.want = '0;
        s.want.entry_value = ev;
        s.want.is_end = ie;
        s.want.first_cluster = fc;
        return s;
    endfunction

    task automatic random_phase(logic [1:0] fmt, logic [27:0] cc, logic [3:0] blk,
                                int pct, int items, int max_cnt);
        int span;
        int sel;
        op_t op;
        logic [27:0] cl;
        logic [27:0] nv;
        logic [15:0] cnt;
        write_reg(REG_FAT_TYPE, 28'(fmt));
        write_reg(REG_CLUSTER_COUNT, cc);
        write_reg(REG_BLOCK_LOG2, 28'(blk));
        gap_pct = pct;
        span = (cc > 400) ? 400 : int'(cc) + 4;
        for (int i = 0; i < items; i++)
        begin
            sel = $urandom_range(99);
            op = (sel < 35) ? OP_READ : (sel < 65) ? OP_WRITE : (sel < 85) ? OP_RESERVE : OP_FLUSH;
            sel = $urandom_range(99);
            cl = (sel < 70) ? 28'($urandom_range(0, span)) :
                 (sel < 85) ? 28'($urandom_range(0, 50000)) : 28'($urandom);
            sel = $urandom_range(99);
            nv = (sel < 40) ? 28'($urandom_range(0, span)) : (sel < 60) ? 28'd0 :
                 (sel < 70) ? 28'hFFFFFFF : 28'($urandom);
            if (op == OP_RESERVE && $urandom_range(99) < 50)
                cl = 28'd0;
            cnt = ($urandom_range(99) < 5 && max_cnt > 8) ? 16'($urandom) :
                  16'($urandom_range(0, (max_cnt > 8) ? 8 : max_cnt));
            send_item(op, cl, nv, cnt, 1'b0, '0);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        operation = '0;
        cluster = '0;
        next_value = '0;
        alloc_count = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        gap_pct = 0;
        for (int i = 0; i < STORE_BYTES; i++)
            fat_store[i] = 8'h00;
        dirty_lo = DIRTY_LOW_INIT;
        dirty_hi = 32'd0;
        fat_fmt = FAT16;
        clus_limit = 28'd0;
        blk_log2 = 4'd9;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        rows.push_back(cmd_row(OP_READ, 28'd0, 28'd0, 16'd0, 1'b1, 28'd0, 1'b0, 28'd0));
        rows.push_back(cmd_row(OP_FLUSH, 28'd0, 28'd0, 16'd0, 1'b1, 28'd0, 1'b0, 28'd0));
        rows.push_back(cmd_row(OP_RESERVE, 28'd0, 28'd0, 16'd5, 1'b1, 28'd0, 1'b0, 28'd0));
        rows.push_back(cmd_row(OP_WRITE, 28'd2, 28'hFFFFFFF, 16'd0, 1'b1, 28'd0, 1'b0, 28'd0));
        rows.push_back(cmd_row(OP_READ, 28'd2, 28'd0, 16'd0, 1'b1, 28'hFFFF, 1'b1, 28'd0));
        rows.push_back(cmd_row(OP_WRITE, 28'hFFFFFFF, 28'h1234, 16'd0, 1'b1, 28'd0, 1'b0,
                               28'd0));
        rows.push_back(cmd_row(OP_READ, 28'hFFFFFFF, 28'd0, 16'd0, 1'b1, 28'd0, 1'b0, 28'd0));
        rows.push_back(cmd_row(OP_FLUSH, 28'd0, 28'd0, 16'd0, 1'b0, 28'd0, 1'b0, 28'd0));
        rows.push_back(cmd_row(OP_FLUSH, 28'd0, 28'd0, 16'd0, 1'b1, 28'd0, 1'b0, 28'd0));
        rows.push_back(cfg_row(REG_FAT_TYPE, 28'(FAT12)));
        rows.push_back(cfg_row(REG_CLUSTER_COUNT, 28'd40));
        rows.push_back(cfg_row(REG_BLOCK_LOG2, 28'd0));
        rows.push_back(cmd_row(OP_WRITE, 28'd3, 28'hABC, 16'd0, 1'b0, 28'd0, 1'b0, 28'd0));
        rows.push_back(cmd_row(OP_WRITE, 28'd4, 28'h123, 16'd0, 1'b0, 28'd0, 1'b0, 28'd0));
        rows.push_back(cmd_row(OP_READ, 28'd3, 28'd0, 16'd0, 1'b0, 28'd0, 1'b0, 28'd0));
        rows.push_back(cmd_row(OP_READ, 28'd4, 28'd0, 16'd0, 1'b0, 28'd0, 1'b0, 28'd0));
        rows.push_back(cmd_row(OP_WRITE, 28'd5, 28'hFFF, 16'd0, 1'b0, 28'd0, 1'b0, 28'd0));
        rows.push_back(cmd_row(OP_READ, 28'd5, 28'd0, 16'd0, 1'b1, 28'hFFF, 1'b1, 28'd0));
        rows.push_back(cmd_row(OP_RESERVE, 28'd5, 28'd0, 16'd3, 1'b0, 28'd0, 1'b0, 28'd0));
        rows.push_back(cmd_row(OP_RESERVE, 28'd0, 28'd0, 16'hFFFF, 1'b0, 28'd0, 1'b0, 28'd0));
        rows.push_back(cmd_row(OP_WRITE, 28'd10, 28'd0, 16'd0, 1'b0, 28'd0, 1'b0, 28'd0));
        rows.push_back(cmd_row(OP_RESERVE, 28'd10, 28'd0, 16'd1, 1'b0, 28'd0, 1'b0, 28'd0));
        rows.push_back(cmd_row(OP_FLUSH, 28'd0, 28'd0, 16'd0, 1'b0, 28'd0, 1'b0, 28'd0));
        rows.push_back(cfg_row(REG_FAT_TYPE, 28'd3));
        rows.push_back(cfg_row(REG_BLOCK_LOG2, 28'd15));
        rows.push_back(cmd_row(OP_WRITE, 28'd7, 28'hFFFFFFF, 16'd0, 1'b0, 28'd0, 1'b0, 28'd0));
        rows.push_back(cmd_row(OP_READ, 28'd7, 28'd0, 16'd0, 1'b1, 28'hFFFFFFF, 1'b1, 28'd0));
        rows.push_back(cmd_row(OP_FLUSH, 28'd0, 28'd0, 16'd0, 1'b0, 28'd0, 1'b0, 28'd0));

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            else
                send_item(rows[i].op, rows[i].cl, rows[i].nv, rows[i].cnt,
                          rows[i].typed, rows[i].want);
        end

        random_phase(FAT12, 28'd200, 4'd9, 0, 150, 65535);
        random_phase(FAT16, 28'd300, 4'd4, 48, 150, 65535);
        random_phase(2'd2, 28'd150, 4'd12, 28, 150, 65535);
        random_phase(2'd3, 28'hFFFFFFF, 4'd13, 0, 150, 2);
        random_phase(FAT12, 28'd2, 4'd0, 48, 140, 65535);
        random_phase(FAT16, 28'd100, 4'd9, 0, 140, 65535);

        start <= 1'b0;
        drain();
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
hdl/fte_pkg.sv
hdl/fte_ram.sv
hdl/fat_table_engine_core.sv
dv/testbench.sv
